// ===== hw/rtl/srs_pkg.sv =====
// shared constants, payload types and back-end state codes for the striped read splitter
`default_nettype none

package srs_pkg;

	localparam int unsigned SECTOR_BYTES    = 4096;
	localparam int unsigned SECTORS_PER_CMD = 16;
	localparam int unsigned ZONES_PER_NODE  = 8;
	localparam int unsigned MAX_CMDS        = 64;
	localparam int unsigned QUEUE_DEPTH     = 4;

	localparam int unsigned OFFSET_W = 40;
	localparam int unsigned COUNT_W  = 23;
	localparam int unsigned ZONE_W   = 3;
	localparam int unsigned ZOFF_W   = 25;
	localparam int unsigned NSEC_W   = 5;
	localparam int unsigned COPY_W   = 17;
	localparam int unsigned SKIP_W   = 12;

	localparam int unsigned SEC_W   = $clog2(SECTOR_BYTES);
	localparam int unsigned RUN_W   = (SECTORS_PER_CMD > 1) ? $clog2(SECTORS_PER_CMD) : 1;
	localparam int unsigned LEVEL_W = ZOFF_W;
	localparam int unsigned SPAN_W  = COUNT_W + 1;
	localparam int unsigned STOT_W  = SPAN_W - SEC_W + 1;
	localparam int unsigned SSTART_W = OFFSET_W - SEC_W;

	typedef struct packed {
		logic [OFFSET_W-1:0] byte_offset;
		logic [COUNT_W-1:0]  byte_count;
	} req_t;

	typedef struct packed {
		logic [ZONE_W-1:0] zone_index;
		logic [ZOFF_W-1:0] zone_sector_offset;
		logic [NSEC_W-1:0] sector_count;
		logic [COUNT_W-1:0] buffer_offset;
		logic [COPY_W-1:0] copy_bytes;
		logic [SKIP_W-1:0] skip_bytes;
		logic              last_command;
		logic              split_error;
	} cmd_t;

	// classified request handed from front to back
	typedef struct packed {
		logic               err;
		logic [ZONE_W-1:0]  zone;
		logic [LEVEL_W-1:0] level;
		logic [RUN_W-1:0]   run;
		logic [STOT_W-1:0]  sec_total;
		logic [COUNT_W-1:0] count;
		logic [SKIP_W-1:0]  skip;
	} desc_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/striped_read_splitter.sv =====
// top level of the striped read splitter: front classifier, descriptor queue, command sequencer
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_stall
//   cmd     | out       | cmd_t   | cmd_valid / cmd_stall
//
// a request is held in the front register, then waits in the descriptor queue
// the back end loads a descriptor and then emits one command per cycle while cmd_stall
// does not hold the output register; the command sequencer sets the rate
// an oversized request yields a single error transaction
// reset clears the front valid, queue pointers, sequencer state and output valid
// cmd_stall holds the output register; the queue lets the front keep accepting meanwhile until it is full
`default_nettype none

module striped_read_splitter import srs_pkg::*; #(
	parameter int unsigned Q_DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      cmd_valid,
	input  wire logic cmd_stall,
	output cmd_t      cmd
);

	logic  push;
	desc_t push_desc;
	logic  q_full;
	logic  pop;
	desc_t pop_desc;
	logic  q_valid;

	srs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	srs_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.not_empty (q_valid)
	);

	srs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_desc    (pop_desc),
		.pop       (pop),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/srs_front.sv =====
// front end: registers a request, classifies it and pushes a descriptor to the queue
`default_nettype none

module srs_front import srs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_stall,
	input  wire req_t  req,
	output logic       push,
	output desc_t      push_desc,
	input  wire logic  q_full
);

	logic                s1_valid_q;
	req_t                req_s1;
	logic [SEC_W-1:0]    skip;
	logic [SPAN_W-1:0]   span;
	logic [STOT_W-1:0]   sec_total;
	logic [SSTART_W-1:0] start_sector;
	logic [NSEC_W-1:0]   room;
	logic [STOT_W-1:0]   first;
	logic [STOT_W-1:0]   rest;
	logic                empty;
	logic                take;

	always_comb begin
		skip         = SEC_W'(req_s1.byte_offset % SECTOR_BYTES);
		span         = SPAN_W'(req_s1.byte_count) + SPAN_W'(skip);
		sec_total    = STOT_W'(span / SECTOR_BYTES) + STOT_W'((span % SECTOR_BYTES) != 0);
		start_sector = SSTART_W'(req_s1.byte_offset / SECTOR_BYTES);
		room         = NSEC_W'(SECTORS_PER_CMD) - NSEC_W'(start_sector % SECTORS_PER_CMD);
		first        = (STOT_W'(room) > sec_total) ? sec_total : STOT_W'(room);
		rest         = sec_total - first;
		empty        = (sec_total == '0);

		push_desc.err       = (rest > STOT_W'((MAX_CMDS - 1) * SECTORS_PER_CMD));
		push_desc.zone      = ZONE_W'((start_sector / SECTORS_PER_CMD) % ZONES_PER_NODE);
		push_desc.level     = LEVEL_W'(start_sector / (SECTORS_PER_CMD * ZONES_PER_NODE));
		push_desc.run       = RUN_W'(start_sector % SECTORS_PER_CMD);
		push_desc.sec_total = sec_total;
		push_desc.count     = req_s1.byte_count;
		push_desc.skip      = SKIP_W'(skip);
	end

	// a request covering no sectors is dropped here
	assign take      = s1_valid_q && (empty || !q_full);
	assign push      = s1_valid_q && !empty && !q_full;
	assign req_stall = s1_valid_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_valid && !req_stall) begin
			s1_valid_q <= 1'b1;
		end else if (take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/srs_queue.sv =====
// small descriptor fifo between front and back
`default_nettype none

module srs_queue import srs_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	output logic       full,
	input  wire logic  pop,
	output desc_t      pop_desc,
	output logic       not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (fill_q == CNT_W'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/srs_back.sv =====
// back end: walks a descriptor and emits one media command per cycle while cmd_stall does not hold the output
`default_nettype none

module srs_back import srs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire desc_t q_desc,
	output logic       pop,
	output logic       cmd_valid,
	input  wire logic  cmd_stall,
	output cmd_t       cmd
);

	back_state_t        state_q;
	back_state_t        state_next;
	logic               err_q;
	logic               first_q;
	logic [ZONE_W-1:0]  zone_q;
	logic [LEVEL_W-1:0] level_q;
	logic [RUN_W-1:0]   run_q;
	logic [STOT_W-1:0]  secs_rem_q;
	logic [COUNT_W-1:0] left_q;
	logic [COUNT_W-1:0] boff_q;
	logic [SKIP_W-1:0]  skip_q;
	logic               cmd_valid_q;
	cmd_t               cmd_q;

	logic [NSEC_W-1:0]  lim;
	logic [NSEC_W-1:0]  nsec;
	logic [COPY_W-1:0]  avail;
	logic [COPY_W-1:0]  cp;
	logic [STOT_W-1:0]  sec_next;
	logic               last;
	logic               zone_wrap;
	logic               out_free;
	logic               emit;
	logic               done;
	cmd_t               cmd_next;

	always_comb begin
		lim       = NSEC_W'(SECTORS_PER_CMD) - (first_q ? NSEC_W'(run_q) : '0);
		nsec      = (STOT_W'(lim) < secs_rem_q) ? lim : NSEC_W'(secs_rem_q);
		avail     = COPY_W'(nsec) * COPY_W'(SECTOR_BYTES) - COPY_W'(skip_q);
		cp        = (COUNT_W'(avail) > left_q) ? COPY_W'(left_q) : avail;
		sec_next  = secs_rem_q - STOT_W'(nsec);
		last      = (sec_next == '0);
		zone_wrap = (zone_q == ZONE_W'(ZONES_PER_NODE - 1));

		cmd_next = '0;
		if (err_q) begin
			cmd_next.split_error = 1'b1;
		end else begin
			cmd_next.zone_index         = zone_q;
			cmd_next.zone_sector_offset = ZOFF_W'(level_q * SECTORS_PER_CMD)
				+ (first_q ? ZOFF_W'(run_q) : '0);
			cmd_next.sector_count       = nsec;
			cmd_next.buffer_offset      = boff_q;
			cmd_next.copy_bytes         = cp;
			cmd_next.skip_bytes         = skip_q;
			cmd_next.last_command       = last;
		end
	end

	assign out_free = !cmd_valid_q || !cmd_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_next = BK_RUN;
				end
			end
			BK_RUN: begin
				if (done) begin
					state_next = BK_IDLE;
				end
			end
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = (state_q == BK_IDLE) && q_valid;
		emit = (state_q == BK_RUN) && out_free;
		done = emit && (err_q || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cmd_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (emit) begin
				cmd_valid_q <= 1'b1;
			end else if (!cmd_stall) begin
				cmd_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			err_q      <= q_desc.err;
			first_q    <= 1'b1;
			zone_q     <= q_desc.zone;
			level_q    <= q_desc.level;
			run_q      <= q_desc.run;
			secs_rem_q <= q_desc.sec_total;
			left_q     <= q_desc.count;
			boff_q     <= '0;
			skip_q     <= q_desc.skip;
		end else if (emit) begin
			first_q    <= 1'b0;
			secs_rem_q <= sec_next;
			left_q     <= left_q - COUNT_W'(cp);
			boff_q     <= boff_q + COUNT_W'(cp);
			skip_q     <= '0;
			// step to the next zone, wrapping into the next stripe level
			zone_q     <= zone_wrap ? '0 : zone_q + 1'b1;
			if (zone_wrap) begin
				level_q <= level_q + 1'b1;
			end
		end
		if (emit) begin
			cmd_q <= cmd_next;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_check.sv =====
// port-level checker for the striped read splitter and its bind
`default_nettype none

module srs_check import srs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic cmd_valid,
	input wire logic cmd_stall,
	input wire cmd_t cmd
);

	// a stalled request transaction keeps its payload
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	// a stalled command transaction keeps its payload
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("command changed while stalled");

	// an error result carries nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.split_error |-> !cmd.last_command && cmd.sector_count == '0
			&& cmd.copy_bytes == '0 && cmd.buffer_offset == '0)
		else $error("error result with nonzero fields");

	// a real command reads between one and a full run of sectors
	a_nsec_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd.split_error |-> cmd.sector_count != '0
			&& cmd.sector_count <= NSEC_W'(SECTORS_PER_CMD))
		else $error("sector count out of range");

	// leading skip only on the first command of a request
	a_skip_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.skip_bytes != '0 |-> cmd.buffer_offset == '0)
		else $error("skip bytes on a later command");

endmodule

bind striped_read_splitter srs_check u_srs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd)
);

`default_nettype wire

// ===== bench/striped_read_splitter_tb.sv =====
// self-checking testbench for the striped read splitter: directed request table, then random requests
module striped_read_splitter_tb import srs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		ROW_PREDICTED,
		ROW_SILENT,
		ROW_SINGLE
	} row_kind_t;

	typedef struct packed {
		req_t      rq;
		row_kind_t kind;
		cmd_t      want;
	} stim_row_t;

	localparam logic [OFFSET_W-1:0] TOP_BYTE  = '1;
	localparam logic [COUNT_W-1:0]  MAX_COUNT = 23'd4194304;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic cmd_valid;
	logic cmd_stall = 1'b0;
	cmd_t cmd;

	cmd_t      pending_cmds[$];
	stim_row_t directed[$];
	int        mismatch_count = 0;
	int        stall_left = 0;
	bit        quiet = 1'b0;

	striped_read_splitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic cmd_t make_cmd(input longint unsigned zone, input longint unsigned zoff,
			input longint unsigned nsec, input longint unsigned boff,
			input longint unsigned cp, input longint unsigned skip,
			input bit last, input bit err);
		cmd_t c;
		c.zone_index         = zone[ZONE_W-1:0];
		c.zone_sector_offset = zoff[ZOFF_W-1:0];
		c.sector_count       = nsec[NSEC_W-1:0];
		c.buffer_offset      = boff[COUNT_W-1:0];
		c.copy_bytes         = cp[COPY_W-1:0];
		c.skip_bytes         = skip[SKIP_W-1:0];
		c.last_command       = last;
		c.split_error        = err;
		return c;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		else if (roll < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// queues the media commands one read request turns into
	task automatic split_into_commands(input req_t r);
		longint unsigned off, cnt, skip, span, sec_total, start_sector;
		longint unsigned level, in_level, zone, in_run;
		longint unsigned first, rest, ncmd, secs_rem, left, boff, nsec, zoff, avail, cp;
		int k;
		bit last;
		off          = r.byte_offset;
		cnt          = r.byte_count;
		skip         = off % SECTOR_BYTES;
		span         = cnt + skip;
		sec_total    = (span + SECTOR_BYTES - 1) / SECTOR_BYTES;
		start_sector = off / SECTOR_BYTES;
		level        = start_sector / (ZONES_PER_NODE * SECTORS_PER_CMD);
		in_level     = start_sector % (ZONES_PER_NODE * SECTORS_PER_CMD);
		zone         = in_level / SECTORS_PER_CMD;
		in_run       = in_level % SECTORS_PER_CMD;
		if (sec_total == 0)
			return;
		first = SECTORS_PER_CMD - in_run;
		if (first > sec_total)
			first = sec_total;
		rest = sec_total - first;
		ncmd = 1 + (rest + SECTORS_PER_CMD - 1) / SECTORS_PER_CMD;
		if (ncmd > MAX_CMDS) begin
			pending_cmds.push_back(make_cmd(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
			return;
		end
		secs_rem = sec_total;
		left     = cnt;
		boff     = 0;
		nsec     = first;
		zoff     = level * SECTORS_PER_CMD + in_run;
		k        = 0;
		forever begin
			avail = nsec * SECTOR_BYTES - skip;
			cp    = (avail > left) ? left : avail;
			secs_rem -= nsec;
			left     -= cp;
			last      = (secs_rem == 0);
			pending_cmds.push_back(make_cmd(zone, zoff, nsec, boff, cp, skip, last, 1'b0));
			k++;
			if (last || k >= MAX_CMDS)
				break;
			zone = (zone + 1) % ZONES_PER_NODE;
			if (zone == 0)
				level++;
			zoff = level * SECTORS_PER_CMD;
			nsec = (secs_rem > SECTORS_PER_CMD) ? SECTORS_PER_CMD : secs_rem;
			boff += cp;
			skip  = 0;
		end
	endtask

	task automatic check_cmd(input cmd_t got);
		cmd_t want;
		if (pending_cmds.size() == 0) begin
			$error("unexpected command transaction: %p", got);
			mismatch_count++;
			return;
		end
		want = pending_cmds.pop_front();
		if (got.zone_index !== want.zone_index) begin
			$error("zone_index: expected %0d, got %0d", want.zone_index, got.zone_index);
			mismatch_count++;
		end
		if (got.zone_sector_offset !== want.zone_sector_offset) begin
			$error("zone_sector_offset: expected %0d, got %0d",
				want.zone_sector_offset, got.zone_sector_offset);
			mismatch_count++;
		end
		if (got.sector_count !== want.sector_count) begin
			$error("sector_count: expected %0d, got %0d", want.sector_count, got.sector_count);
			mismatch_count++;
		end
		if (got.buffer_offset !== want.buffer_offset) begin
			$error("buffer_offset: expected %0d, got %0d", want.buffer_offset, got.buffer_offset);
			mismatch_count++;
		end
		if (got.copy_bytes !== want.copy_bytes) begin
			$error("copy_bytes: expected %0d, got %0d", want.copy_bytes, got.copy_bytes);
			mismatch_count++;
		end
		if (got.skip_bytes !== want.skip_bytes) begin
			$error("skip_bytes: expected %0d, got %0d", want.skip_bytes, got.skip_bytes);
			mismatch_count++;
		end
		if (got.last_command !== want.last_command) begin
			$error("last_command: expected %0d, got %0d", want.last_command, got.last_command);
			mismatch_count++;
		end
		if (got.split_error !== want.split_error) begin
			$error("split_error: expected %0d, got %0d", want.split_error, got.split_error);
			mismatch_count++;
		end
	endtask

	// call at a rising edge; returns at the edge the transaction is accepted, or after the gap
	task automatic send_request(input req_t r, input row_kind_t kind, input cmd_t want);
		int gap;
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
		case (kind)
			ROW_SINGLE: begin
				pending_cmds.push_back(want);
			end
			ROW_PREDICTED: begin
				split_into_commands(r);
			end
			default: begin
			end
		endcase
		gap = (quiet || $urandom_range(0, 1)) ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic [OFFSET_W-1:0] off, input logic [COUNT_W-1:0] cnt,
			input row_kind_t kind, input cmd_t want);
		stim_row_t row;
		row.rq.byte_offset = off;
		row.rq.byte_count  = cnt;
		row.kind           = kind;
		row.want           = want;
		directed.push_back(row);
	endtask

	// command side: random stall, check every accepted transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_stall <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall)
				check_cmd(cmd);
			if (stall_left > 0) begin
				stall_left--;
				cmd_stall <= 1'b1;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				cmd_stall <= 1'b0;
			end else begin
				stall_left = pick_gap() - 1;
				cmd_stall <= 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		req_t        r;
		logic [63:0] rnd;
		int          sel;

		// typed rows: nothing, single commands, oversized splits, top sector of the space
		add_row(40'd0, 23'd0, ROW_SILENT, '0);
		add_row(40'd0, 23'd1, ROW_SINGLE, make_cmd(0, 0, 1, 0, 1, 0, 1'b1, 1'b0));
		add_row(40'd0, 23'd4096, ROW_SINGLE, make_cmd(0, 0, 1, 0, 4096, 0, 1'b1, 1'b0));
		add_row(40'd4095, 23'd0, ROW_SINGLE, make_cmd(0, 0, 1, 0, 0, 4095, 1'b1, 1'b0));
		add_row(40'd65535, 23'd0, ROW_SINGLE, make_cmd(0, 15, 1, 0, 0, 4095, 1'b1, 1'b0));
		add_row(40'd1, MAX_COUNT, ROW_SINGLE, make_cmd(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
		add_row(TOP_BYTE, MAX_COUNT, ROW_SINGLE, make_cmd(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
		add_row(TOP_BYTE - 40'd4095, 23'd4096, ROW_SINGLE,
			make_cmd(7, 33554431, 1, 0, 4096, 0, 1'b1, 1'b0));
		// longest legal splits and wrap past the top of the space
		add_row(40'd0, MAX_COUNT, ROW_PREDICTED, '0);
		add_row(40'd0, MAX_COUNT - 23'd1, ROW_PREDICTED, '0);
		add_row(40'd100, MAX_COUNT - 23'd100, ROW_PREDICTED, '0);
		add_row(TOP_BYTE - 40'd12287, 23'd163840, ROW_PREDICTED, '0);
		add_row(TOP_BYTE, 23'd2, ROW_PREDICTED, '0);
		add_row(TOP_BYTE, 23'd1, ROW_PREDICTED, '0);
		add_row(40'd4095, 23'd2, ROW_PREDICTED, '0);
		add_row(40'd12345, 23'd100000, ROW_PREDICTED, '0);
		add_row(40'd520192, 23'd8192, ROW_PREDICTED, '0);
		add_row(40'hAA_AAAA_AAAA, 23'h55_5555, ROW_PREDICTED, '0);
		add_row(40'h55_5555_5555, 23'h2A_AAAA, ROW_PREDICTED, '0);
		add_row(40'd20487, 23'd65536, ROW_PREDICTED, '0);
		add_row(40'd65536, 23'd69632, ROW_PREDICTED, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i].rq, directed[i].kind, directed[i].want);

		for (int i = 0; i < 250; i++) begin
			quiet = (i % 60) >= 45;
			rnd = {$urandom, $urandom};
			sel = $urandom_range(0, 9);
			if (sel < 5)
				r.byte_offset = rnd[OFFSET_W-1:0];
			else if (sel < 7)
				r.byte_offset = 40'($urandom_range(0, 1 << 20));
			else if (sel == 7)
				r.byte_offset = TOP_BYTE - 40'($urandom_range(0, 1 << 22));
			else if (sel == 8)
				r.byte_offset = {rnd[OFFSET_W-1:SEC_W], {SEC_W{1'b0}}};
			else
				// near the end of a sector within a zone run
				r.byte_offset = {rnd[OFFSET_W-1:16], 16'd0}
					+ 40'($urandom_range(0, 15) * SECTOR_BYTES)
					+ 40'($urandom_range(4090, 4095));
			sel = $urandom_range(0, 9);
			if (sel < 4)
				r.byte_count = 23'($urandom_range(0, 8192));
			else if (sel < 7)
				r.byte_count = 23'($urandom_range(0, 262144));
			else if (sel < 9)
				r.byte_count = 23'($urandom_range(0, 4194304));
			else
				// around the command limit
				r.byte_count = MAX_COUNT - 23'($urandom_range(0, 8192));
			send_request(r, ROW_PREDICTED, '0);
		end
		req_valid <= 1'b0;
		quiet = 1'b1;

		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
